// ===== hdl/scv_pkg.sv =====
// ----------------------------------------------------------------------------
// scv_pkg
// Shared types and constants of the strided, padded 1-D correlation block.
// ----------------------------------------------------------------------------
package scv_pkg;

	localparam int MAX_SAMPLES  = 64;
	localparam int MAX_TAPS     = 15;
	localparam int SAMPLE_BITS  = 16;
	localparam int ACC_BITS     = 40;
	localparam int PROD_BITS    = 2 * SAMPLE_BITS;

	localparam int SAMPLE_AW    = $clog2(MAX_SAMPLES);
	localparam int TAP_AW       = $clog2(MAX_TAPS);
	localparam int CNT_BITS     = $clog2(MAX_SAMPLES + 1);
	localparam int POS_BITS     = CNT_BITS + 1;

	// Register widths and reset values
	localparam int KLEN_BITS    = 4;
	localparam int STEP_BITS    = 7;
	localparam int PAD_BITS     = 2;
	localparam int CFG_BITS     = 7;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [KLEN_BITS-1:0] KLEN_RESET = 4'd3;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 7'd1;
	localparam logic [PAD_BITS-1:0]  PAD_RESET  = 2'd0;

	// Register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_KLEN = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_STEP = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_PAD  = 2'd2;

	// Pad modes
	localparam logic [PAD_BITS-1:0] PAD_ZERO = 2'd0;
	localparam logic [PAD_BITS-1:0] PAD_HALF = 2'd1;
	localparam logic [PAD_BITS-1:0] PAD_COPY = 2'd2;

	// Input kinds carried on tuser
	localparam logic OP_TAP    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Stream widths
	localparam int S_TDATA_BITS = 24;  // tap_index[3:0], value[19:4], zero fill
	localparam int M_TDATA_BITS = 40;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_ERR
	} state_t;

	typedef enum logic [1:0] {
		SRC_LEFT,
		SRC_MID,
		SRC_RIGHT
	} src_t;

	function automatic logic signed [SAMPLE_BITS-1:0] pad_value(
		input logic [PAD_BITS-1:0]          mode,
		input logic signed [SAMPLE_BITS-1:0] edge_smp
	);
		logic signed [SAMPLE_BITS-1:0] res;
		case (mode)
			PAD_HALF: res = edge_smp >>> 1;
			PAD_COPY: res = edge_smp;
			default:  res = '0;
		endcase
		return res;
	endfunction

endpackage

// ===== hdl/scv_ram.sv =====
// ----------------------------------------------------------------------------
// scv_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/strided_conv1d_padded.sv =====
// ----------------------------------------------------------------------------
// strided_conv1d_padded
// Strided 1-D correlation of a stored sample run with edge padding.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser = 0 writes a kernel tap, tuser = 1 delivers a
//   sample; tlast on a sample closes the run. Both are taken at one beat per
//   cycle while the block is idle. Up to 64 samples are stored; later ones
//   are dropped until tlast.
//   Output stream m_*: one beat per window start 0, step, 2*step, ... below
//   the sample count, tdata holds the saturated 40-bit sum, tlast marks the
//   last window. Zero step or kernel length, or kernel > run: one beat, tuser = 1.
//   Config port: cfg_we writes register cfg_index (0 kernel length, 1 step,
//   2 pad mode) at once; write only while idle.
// Timing:
//   Each window issues one tap per cycle, unless a stall freezes the pipe,
//   through the RAMs, a registered multiplier and the accumulator; the
//   sum is saturated into the output register. An error beat is loaded
//   from the error state. New input beats wait until the tap pipeline has
//   drained; the last result may still sit in the output register.
// Reset and stall:
//   arst_n clears control state and loads register defaults; stored taps
//   and samples are undefined until written. A finished window that meets a
//   full output register with m_tready low freezes the tap pipeline.
// ----------------------------------------------------------------------------
module strided_conv1d_padded (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [scv_pkg::S_TDATA_BITS-1:0]  s_tdata,   // tap_index[3:0], value[19:4]
	input  logic                              s_tuser,   // op
	input  logic                              s_tlast,   // last_sample

	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [scv_pkg::M_TDATA_BITS-1:0]  m_tdata,   // out_value[39:0]
	output logic                              m_tuser,   // error
	output logic                              m_tlast,   // final_res

	input  logic                              cfg_we,
	input  logic [scv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [scv_pkg::CFG_BITS-1:0]      cfg_data
);

	localparam int SB = scv_pkg::SAMPLE_BITS;
	localparam int AB = scv_pkg::ACC_BITS;
	localparam int PB = scv_pkg::POS_BITS;
	localparam int CB = scv_pkg::CNT_BITS;

	// Configuration registers
	logic [scv_pkg::KLEN_BITS-1:0] klen_q;
	logic [scv_pkg::STEP_BITS-1:0] step_q;
	logic [scv_pkg::PAD_BITS-1:0]  pad_q;

	// Run control
	scv_pkg::state_t state_q, state_d;
	logic [CB-1:0]                 count_q;
	logic [CB-1:0]                 n_q;
	logic [CB-1:0]                 count_new;
	logic signed [SB-1:0]          first_q, last_q;
	logic [CB-1:0]                 win_q;
	logic [scv_pkg::TAP_AW-1:0]    tap_q;

	// Input fields
	logic [scv_pkg::TAP_AW-1:0]    in_tap;
	logic signed [SB-1:0]          in_value;
	logic                          in_beat, smp_beat, tap_beat, smp_store, close_beat;
	logic                          run_bad;

	// Issue stage
	logic                          adv;
	logic                          issue;
	logic                          err_load;
	logic [PB-1:0]                 win_sum, q_pos, d_pos, p_pos;
	logic                          win_fin;
	logic                          last_tap;
	scv_pkg::src_t                 src;

	// Pipeline
	logic                          v_s1, first_s1, lt_s1, fin_s1;
	scv_pkg::src_t                 src_s1;
	logic                          v_s2, first_s2, lt_s2, fin_s2;
	logic signed [scv_pkg::PROD_BITS-1:0] prod_s2;
	logic signed [AB-1:0]          acc_q;
	logic signed [AB:0]            sum_w;
	logic signed [AB-1:0]          sat_w;

	// RAM ports
	logic [SB-1:0]                 smp_rdata, tap_rdata;
	logic signed [SB-1:0]          opnd;
	logic signed [SB-1:0]          lpad, rpad;

	// Output register
	logic                          out_v_q;
	logic [AB-1:0]                 out_data_q;
	logic                          out_err_q, out_fin_q;
	logic                          res_load;

	assign in_tap     = s_tdata[scv_pkg::TAP_AW-1:0];
	assign in_value   = s_tdata[scv_pkg::TAP_AW +: SB];
	assign in_beat    = s_tvalid && s_tready;
	assign smp_beat   = in_beat && (s_tuser == scv_pkg::OP_SAMPLE);
	assign tap_beat   = in_beat && (s_tuser == scv_pkg::OP_TAP) &&
	                    (32'(in_tap) < scv_pkg::MAX_TAPS);
	assign smp_store  = smp_beat && (32'(count_q) < scv_pkg::MAX_SAMPLES);
	assign close_beat = smp_beat && s_tlast;
	assign count_new  = smp_store ? count_q + CB'(1) : count_q;

	assign run_bad = (klen_q == '0) || (32'(klen_q) > scv_pkg::MAX_TAPS) ||
	                 (step_q == '0) || (CB'(klen_q) > count_new);

	// ------------------------------------------------------------------
	// Window position and source selection
	// ------------------------------------------------------------------
	assign win_sum  = PB'(win_q) + PB'(step_q);
	assign win_fin  = win_sum >= PB'(n_q);
	assign last_tap = (PB'(tap_q) == PB'(klen_q) - PB'(1));
	assign q_pos    = PB'(win_q) + PB'(tap_q);
	assign p_pos    = (PB'(klen_q) - PB'(1)) >> 1;
	assign d_pos    = q_pos - p_pos;

	always_comb begin
		if (q_pos < p_pos) begin
			src = scv_pkg::SRC_LEFT;
		end else if (d_pos < PB'(n_q)) begin
			src = scv_pkg::SRC_MID;
		end else begin
			src = scv_pkg::SRC_RIGHT;
		end
	end

	// Freeze the tap pipeline while a finished window cannot enter the output register
	assign adv      = !(v_s2 && lt_s2 && out_v_q && !m_tready);
	assign res_load = adv && v_s2 && lt_s2;

	// ------------------------------------------------------------------
	// Control state machine
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			scv_pkg::ST_IDLE: begin
				if (close_beat) begin
					state_d = run_bad ? scv_pkg::ST_ERR : scv_pkg::ST_RUN;
				end
			end
			scv_pkg::ST_RUN: begin
				if (adv && last_tap && win_fin) begin
					state_d = scv_pkg::ST_IDLE;
				end
			end
			scv_pkg::ST_ERR: begin
				if (!out_v_q || m_tready) begin
					state_d = scv_pkg::ST_IDLE;
				end
			end
			default: state_d = scv_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		err_load = 1'b0;
		unique case (state_q)
			scv_pkg::ST_IDLE: s_tready = !v_s1 && !v_s2;
			scv_pkg::ST_RUN:  issue    = adv;
			scv_pkg::ST_ERR:  err_load = !out_v_q || m_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scv_pkg::ST_IDLE;
			klen_q  <= scv_pkg::KLEN_RESET;
			step_q  <= scv_pkg::STEP_RESET;
			pad_q   <= scv_pkg::PAD_RESET;
			count_q <= '0;
			n_q     <= '0;
			win_q   <= '0;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					scv_pkg::REG_KLEN: klen_q <= cfg_data[scv_pkg::KLEN_BITS-1:0];
					scv_pkg::REG_STEP: step_q <= cfg_data[scv_pkg::STEP_BITS-1:0];
					scv_pkg::REG_PAD:  pad_q  <= cfg_data[scv_pkg::PAD_BITS-1:0];
					default: ;
				endcase
			end
			if (close_beat) begin
				n_q     <= count_new;
				count_q <= '0;
				win_q   <= '0;
				tap_q   <= '0;
			end else if (smp_store) begin
				count_q <= count_new;
			end
			if (issue) begin
				if (last_tap) begin
					tap_q <= '0;
					win_q <= win_sum[CB-1:0];
				end else begin
					tap_q <= tap_q + scv_pkg::TAP_AW'(1);
				end
			end
		end
	end

	// Edge samples for padding
	always_ff @(posedge clk) begin
		if (smp_store) begin
			last_q <= in_value;
			if (count_q == '0) begin
				first_q <= in_value;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stores
	// ------------------------------------------------------------------
	scv_ram #(
		.WIDTH (SB),
		.DEPTH (scv_pkg::MAX_SAMPLES)
	) u_smp_ram (
		.clk   (clk),
		.we    (smp_store),
		.waddr (count_q[scv_pkg::SAMPLE_AW-1:0]),
		.wdata (in_value),
		.re    (issue),
		.raddr (d_pos[scv_pkg::SAMPLE_AW-1:0]),
		.rdata (smp_rdata)
	);

	scv_ram #(
		.WIDTH (SB),
		.DEPTH (scv_pkg::MAX_TAPS)
	) u_tap_ram (
		.clk   (clk),
		.we    (tap_beat),
		.waddr (in_tap),
		.wdata (in_value),
		.re    (issue),
		.raddr (tap_q),
		.rdata (tap_rdata)
	);

	// ------------------------------------------------------------------
	// Multiply-accumulate pipeline
	// ------------------------------------------------------------------
	assign lpad = scv_pkg::pad_value(pad_q, first_q);
	assign rpad = scv_pkg::pad_value(pad_q, last_q);

	always_comb begin
		case (src_s1)
			scv_pkg::SRC_LEFT:  opnd = lpad;
			scv_pkg::SRC_MID:   opnd = $signed(smp_rdata);
			default:            opnd = rpad;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			src_s1   <= src;
			first_s1 <= (tap_q == '0);
			lt_s1    <= last_tap;
			fin_s1   <= win_fin;
			prod_s2  <= opnd * $signed(tap_rdata);
			first_s2 <= first_s1;
			lt_s2    <= lt_s1;
			fin_s2   <= fin_s1;
		end
	end

	assign sum_w = (first_s2 ? '0 : (AB+1)'(acc_q)) + (AB+1)'(prod_s2);

	always_comb begin
		if (sum_w[AB] != sum_w[AB-1]) begin
			// Clamp to the signed 40-bit range
			sat_w = sum_w[AB] ? {1'b1, {(AB-1){1'b0}}} : {1'b0, {(AB-1){1'b1}}};
		end else begin
			sat_w = sum_w[AB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= sat_w;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_load || err_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= sat_w;
			out_err_q  <= 1'b0;
			out_fin_q  <= fin_s2;
		end else if (err_load) begin
			out_data_q <= '0;
			out_err_q  <= 1'b1;
			out_fin_q  <= 1'b1;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_err_q;
	assign m_tlast  = out_fin_q;

endmodule
